/* src/dqpc_pkg.sv */
// Package for the dual quaternion pose composer.
// Holds the beat payload types, the Q16.16 constants and the Hamilton product term table.
// No dependencies.
package dqpc_pkg;

    localparam int unsigned COMP_W = 32;
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned PROD_W = 2 * COMP_W;
    localparam int unsigned SUM_W  = PROD_W + 2;
    localparam int unsigned ACC_W  = PROD_W + 3;
    localparam int unsigned NUM_Q  = 4;
    localparam int unsigned IDX_W  = 2;

    localparam logic signed [COMP_W-1:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [COMP_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [COMP_W-1:0] Q_MIN   = 32'sh8000_0000;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPOSE = 1'b1;

    // Hamilton product: component c = sum over t of +/- a[QT_L] * b[QT_R]
    localparam logic [IDX_W-1:0] QT_L [NUM_Q][NUM_Q] = '{
        '{2'd0, 2'd3, 2'd1, 2'd2},
        '{2'd1, 2'd3, 2'd2, 2'd0},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd0, 2'd1, 2'd2}
    };
    localparam logic [IDX_W-1:0] QT_R [NUM_Q][NUM_Q] = '{
        '{2'd3, 2'd0, 2'd2, 2'd1},
        '{2'd3, 2'd1, 2'd0, 2'd2},
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd3, 2'd0, 2'd1, 2'd2}
    };
    localparam logic QT_NEG [NUM_Q][NUM_Q] = '{
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b1, 1'b1, 1'b1}
    };

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [ACC_W-1:0]  t_acc;

    typedef struct packed {
        logic                     kind;
        logic signed [COMP_W-1:0] in_real_x;
        logic signed [COMP_W-1:0] in_real_y;
        logic signed [COMP_W-1:0] in_real_z;
        logic signed [COMP_W-1:0] in_real_w;
        logic signed [COMP_W-1:0] in_dual_x;
        logic signed [COMP_W-1:0] in_dual_y;
        logic signed [COMP_W-1:0] in_dual_z;
        logic signed [COMP_W-1:0] in_dual_w;
    } t_in;

    typedef struct packed {
        logic signed [COMP_W-1:0] out_real_x;
        logic signed [COMP_W-1:0] out_real_y;
        logic signed [COMP_W-1:0] out_real_z;
        logic signed [COMP_W-1:0] out_real_w;
        logic signed [COMP_W-1:0] out_dual_x;
        logic signed [COMP_W-1:0] out_dual_y;
        logic signed [COMP_W-1:0] out_dual_z;
        logic signed [COMP_W-1:0] out_dual_w;
        logic                     saturated;
    } t_out;

endpackage

/* src/dqpc_hamilton.sv */
// Full-precision Hamilton quaternion product a * b, one exact sum per component.
// Sixteen parallel 32x32 signed multiplies; depends on dqpc_pkg.
module dqpc_hamilton
    import dqpc_pkg::*;
(
    input  t_comp i_a   [NUM_Q],
    input  t_comp i_b   [NUM_Q],
    output t_sum  o_sum [NUM_Q]
);

    logic signed [PROD_W-1:0] prod [NUM_Q][NUM_Q];

    always_comb begin
        for (int c = 0; c < NUM_Q; c++) begin
            for (int t = 0; t < NUM_Q; t++) begin
                prod[c][t] = PROD_W'(i_a[QT_L[c][t]]) * PROD_W'(i_b[QT_R[c][t]]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NUM_Q; c++) begin
            o_sum[c] = '0;
            for (int t = 0; t < NUM_Q; t++) begin
                if (QT_NEG[c][t]) begin
                    o_sum[c] = o_sum[c] - SUM_W'(prod[c][t]);
                end else begin
                    o_sum[c] = o_sum[c] + SUM_W'(prod[c][t]);
                end
            end
        end
    end

endmodule

/* src/dqpc_sat.sv */
// Floor shift of a Q35.32 sum down to Q16.16 with saturation to 32 bits.
// Depends on dqpc_pkg.
module dqpc_sat
    import dqpc_pkg::*;
(
    input  t_acc  i_acc,
    output t_comp o_val,
    output logic  o_sat
);

    logic [ACC_W-COMP_W-FRAC_W:0] top_bits;
    logic                         fits;

    assign top_bits = i_acc[ACC_W-1:COMP_W+FRAC_W-1];
    assign fits     = (&top_bits) || !(|top_bits);
    assign o_sat    = !fits;

    always_comb begin
        if (fits) begin
            o_val = i_acc[COMP_W+FRAC_W-1:FRAC_W];
        end else if (i_acc[ACC_W-1]) begin
            o_val = Q_MIN;
        end else begin
            o_val = Q_MAX;
        end
    end

endmodule

/* src/dual_quaternion_pose_composer_top.sv */
// Top level of the dual quaternion pose composer: input register, pose register, result register.
// Depends on dqpc_pkg, dqpc_hamilton and dqpc_sat.
//
//   channel | valid       | ready       | payload
//   --------+-------------+-------------+---------------------
//   in      | i_in_valid  | o_in_ready  | i_in_data  (t_in)
//   out     | o_out_valid | i_out_ready | o_out_data (t_out)
//
// One item per cycle unless the output stalls; a beat is held in r_in, then in r_out.
// On each advance the 48 parallel 32x32 multiplies feed the pose register directly,
// so every compose sees the pose left by the item just before it; a load writes its input there.
// Reset clears both valid flags and loads the identity pose (real w = 1.0).
// A stalled result holds; one more item waits in the input register, then ready drops.
module dual_quaternion_pose_composer_top
    import dqpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    logic  r_in_valid, n_in_valid;
    t_in   r_in;
    logic  r_out_valid, n_out_valid;
    t_out  r_out, n_out;
    t_comp r_pose_real [NUM_Q];
    t_comp r_pose_dual [NUM_Q];

    logic  advance;
    logic  in_beat;
    t_comp b_real [NUM_Q];
    t_comp b_dual [NUM_Q];
    t_sum  s_rr   [NUM_Q];
    t_sum  s_rd   [NUM_Q];
    t_sum  s_dr   [NUM_Q];
    t_acc  acc_real [NUM_Q];
    t_acc  acc_dual [NUM_Q];
    t_comp c_real [NUM_Q];
    t_comp c_dual [NUM_Q];
    logic  sat_real [NUM_Q];
    logic  sat_dual [NUM_Q];
    t_comp res_real [NUM_Q];
    t_comp res_dual [NUM_Q];
    logic  res_sat;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;

    assign b_real[0] = r_in.in_real_x;
    assign b_real[1] = r_in.in_real_y;
    assign b_real[2] = r_in.in_real_z;
    assign b_real[3] = r_in.in_real_w;
    assign b_dual[0] = r_in.in_dual_x;
    assign b_dual[1] = r_in.in_dual_y;
    assign b_dual[2] = r_in.in_dual_z;
    assign b_dual[3] = r_in.in_dual_w;

    dqpc_hamilton u_mul_rr (.i_a(r_pose_real), .i_b(b_real), .o_sum(s_rr));
    dqpc_hamilton u_mul_rd (.i_a(r_pose_real), .i_b(b_dual), .o_sum(s_rd));
    dqpc_hamilton u_mul_dr (.i_a(r_pose_dual), .i_b(b_real), .o_sum(s_dr));

    for (genvar g = 0; g < NUM_Q; g++) begin : g_comp
        assign acc_real[g] = ACC_W'(s_rr[g]);
        assign acc_dual[g] = ACC_W'(s_rd[g]) + ACC_W'(s_dr[g]);

        dqpc_sat u_sat_real (.i_acc(acc_real[g]), .o_val(c_real[g]), .o_sat(sat_real[g]));
        dqpc_sat u_sat_dual (.i_acc(acc_dual[g]), .o_val(c_dual[g]), .o_sat(sat_dual[g]));
    end

    always_comb begin
        res_sat = 1'b0;
        for (int k = 0; k < NUM_Q; k++) begin
            if (r_in.kind == KIND_COMPOSE) begin
                res_real[k] = c_real[k];
                res_dual[k] = c_dual[k];
                res_sat     = res_sat || sat_real[k] || sat_dual[k];
            end else begin
                res_real[k] = b_real[k];
                res_dual[k] = b_dual[k];
            end
        end
    end

    always_comb begin
        n_out.out_real_x = res_real[0];
        n_out.out_real_y = res_real[1];
        n_out.out_real_z = res_real[2];
        n_out.out_real_w = res_real[3];
        n_out.out_dual_x = res_dual[0];
        n_out.out_dual_y = res_dual[1];
        n_out.out_dual_z = res_dual[2];
        n_out.out_dual_w = res_dual[3];
        n_out.saturated  = res_sat;
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_beat) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_Q; k++) begin
                r_pose_real[k] <= (k == NUM_Q - 1) ? ONE_Q16 : t_comp'(0);
                r_pose_dual[k] <= '0;
            end
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_pose_real <= res_real;
                r_pose_dual <= res_dual;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* src/dqpc_checker.sv */
// Port-level checks for the dual quaternion pose composer, bound to the top level.
// Depends on dqpc_pkg and dual_quaternion_pose_composer_top.
module dqpc_checker
    import dqpc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_beat_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 !o_out_valid |=> o_out_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind dual_quaternion_pose_composer_top dqpc_checker u_dqpc_checker (.*);

/* test/tb_dual_quaternion_pose_composer_top.sv */
// Self-checking testbench for dual_quaternion_pose_composer_top: directed table, then random beats.
// Predicts each new pose with 72-bit Hamilton sums, floor shift and clamp; checks every result.
// Depends on dqpc_pkg and the composer RTL.
module tb_dual_quaternion_pose_composer_top
    import dqpc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [71:0] t_wide;
    typedef t_comp t_quad [4];
    typedef logic [31:0] t_word9 [9];

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_row;

    localparam t_wide W_MAX = 72'sh7FFF_FFFF;
    localparam t_wide W_MIN = -72'sh8000_0000;
    localparam int    RANDOM_PER_PHASE = 470;
    localparam int    HOLD_CYCLES = 80;
    localparam string FIELD_NAME [9] = '{"real_x", "real_y", "real_z", "real_w",
                                         "dual_x", "dual_y", "dual_z", "dual_w", "saturated"};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    t_quad pose_real;
    t_quad pose_dual;
    t_out  poses_due [$];
    t_row  plan [$];

    int phase = 0;
    int mismatches = 0;
    int loads_sent = 0;
    int composes_sent = 0;
    int results_seen = 0;
    int sat_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    dual_quaternion_pose_composer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("dual_quaternion_pose_composer_top: mismatch");
        $finish;
    end

    function automatic t_wide wmul(t_comp a, t_comp b);
        t_wide ea;
        t_wide eb;
        ea = a;
        eb = b;
        return ea * eb;
    endfunction

    function automatic t_wide hamilton_sum(t_quad l, t_quad r, int c);
        case (c)
            0: return wmul(l[0], r[3]) + wmul(l[3], r[0]) + wmul(l[1], r[2]) - wmul(l[2], r[1]);
            1: return wmul(l[1], r[3]) + wmul(l[3], r[1]) + wmul(l[2], r[0]) - wmul(l[0], r[2]);
            2: return wmul(l[2], r[3]) + wmul(l[3], r[2]) + wmul(l[0], r[1]) - wmul(l[1], r[0]);
            default: return wmul(l[3], r[3]) - wmul(l[0], r[0]) - wmul(l[1], r[1])
                - wmul(l[2], r[2]);
        endcase
    endfunction

    function automatic t_comp clamp_q16(t_wide s, inout bit sat);
        t_wide v;
        v = s >>> 16;
        if (v > W_MAX) begin
            sat = 1'b1;
            return Q_MAX;
        end
        if (v < W_MIN) begin
            sat = 1'b1;
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    function automatic t_out compose_pose(t_in item);
        t_quad ir;
        t_quad id;
        t_quad nr;
        t_quad nd;
        bit    sat;
        t_out  o;
        sat = 1'b0;
        ir = '{item.in_real_x, item.in_real_y, item.in_real_z, item.in_real_w};
        id = '{item.in_dual_x, item.in_dual_y, item.in_dual_z, item.in_dual_w};
        if (item.kind == KIND_LOAD) begin
            nr = ir;
            nd = id;
        end else begin
            for (int c = 0; c < 4; c++) begin
                nr[c] = clamp_q16(hamilton_sum(pose_real, ir, c), sat);
                nd[c] = clamp_q16(hamilton_sum(pose_real, id, c)
                    + hamilton_sum(pose_dual, ir, c), sat);
            end
        end
        pose_real = nr;
        pose_dual = nd;
        o = '{nr[0], nr[1], nr[2], nr[3], nd[0], nd[1], nd[2], nd[3], sat};
        return o;
    endfunction

    function automatic t_word9 to_words(t_out o);
        t_word9 w;
        w = '{o.out_real_x, o.out_real_y, o.out_real_z, o.out_real_w,
              o.out_dual_x, o.out_dual_y, o.out_dual_z, o.out_dual_w, 32'(o.saturated)};
        return w;
    endfunction

    function automatic t_in mk_in(logic k, t_comp rx, t_comp ry, t_comp rz, t_comp rw,
                                  t_comp dx, t_comp dy, t_comp dz, t_comp dw);
        t_in v;
        v = '{k, rx, ry, rz, rw, dx, dy, dz, dw};
        return v;
    endfunction

    function automatic t_out mk_out(t_comp rx, t_comp ry, t_comp rz, t_comp rw,
                                    t_comp dx, t_comp dy, t_comp dz, t_comp dw, logic s);
        t_out v;
        v = '{rx, ry, rz, rw, dx, dy, dz, dw, s};
        return v;
    endfunction

    function automatic t_comp rand_comp();
        case ($urandom_range(0, 19))
            0, 1: return t_comp'($urandom);
            2: begin
                case ($urandom_range(0, 3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return t_comp'($urandom_range(0, 32'h0002_0000)) - ONE_Q16;
        endcase
    endfunction

    function automatic t_in rand_item();
        logic k;
        k = ($urandom_range(0, 99) < 15) ? KIND_LOAD : KIND_COMPOSE;
        return mk_in(k, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                     rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endfunction

    task automatic add_row(t_in item, bit typed, t_out want);
        t_row r;
        r.item = item;
        r.typed = typed;
        r.want = want;
        plan.push_back(r);
    endtask

    task automatic drive_beat(t_in item, bit typed, t_out want);
        int idle_pct;
        t_out pred;
        idle_pct = (phase == 1) ? 82 : (phase == 3) ? 36 : 0;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (!o_in_ready);
        pred = compose_pose(item);
        poses_due.push_back(typed ? want : pred);
        if (item.kind == KIND_LOAD)
            loads_sent++;
        else
            composes_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (poses_due.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        int stall_pct;
        stall_pct = (phase == 2) ? 82 : (phase == 3) ? 36 : 0;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (phase == 0 && !hold_done && results_seen >= 300) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out   want;
        t_word9 got_w;
        t_word9 want_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            if (poses_due.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result beat: %h", o_out_data);
                mismatches++;
            end else begin
                want = poses_due.pop_front();
                if (want.saturated)
                    sat_seen++;
                got_w = to_words(o_out_data);
                want_w = to_words(want);
                for (int f = 0; f < 9; f++) begin
                    if (got_w[f] !== want_w[f]) begin
                        if (mismatches < 10)
                            $display("result %0d %s: expected %h, got %h",
                                     results_seen, FIELD_NAME[f], want_w[f], got_w[f]);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        t_in  vec_a;
        t_in  vec_b;
        pose_real = '{32'sd0, 32'sd0, 32'sd0, ONE_Q16};
        pose_dual = '{32'sd0, 32'sd0, 32'sd0, 32'sd0};

        vec_a = mk_in(KIND_COMPOSE, 32'sh0001_8000, -32'sh0002_0000, 32'sh0003_0000,
                      32'sh0000_4000, 32'sh0007_0000, -32'sh0008_0000, 32'sh0000_2000,
                      -32'sh0001_0000);
        vec_b = mk_in(KIND_COMPOSE, 32'sh0000_B505, -32'sh0000_3A12, 32'sh0000_1F0C,
                      32'sh0000_B505, -32'sh0004_8000, 32'sh0012_3456, -32'sh0000_0001,
                      32'sh7FFF_0000);

        add_row(mk_in(KIND_COMPOSE, '0, '0, '0, ONE_Q16, '0, '0, '0, '0), 1'b1,
                mk_out('0, '0, '0, ONE_Q16, '0, '0, '0, '0, 1'b0));
        add_row(vec_a, 1'b1, mk_out(vec_a.in_real_x, vec_a.in_real_y, vec_a.in_real_z,
                vec_a.in_real_w, vec_a.in_dual_x, vec_a.in_dual_y, vec_a.in_dual_z,
                vec_a.in_dual_w, 1'b0));
        add_row(vec_b, 1'b0, '0);
        add_row(mk_in(KIND_LOAD, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX),
                1'b1, mk_out(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0));
        add_row(mk_in(KIND_COMPOSE, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX),
                1'b1, mk_out(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b1));
        add_row(mk_in(KIND_LOAD, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN),
                1'b1, mk_out(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0));
        add_row(mk_in(KIND_COMPOSE, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN),
                1'b1, mk_out(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 1'b1));
        add_row(mk_in(KIND_LOAD, '0, '0, '0, '0, '0, '0, '0, '0), 1'b1,
                mk_out('0, '0, '0, '0, '0, '0, '0, '0, 1'b0));
        add_row(mk_in(KIND_COMPOSE, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX),
                1'b1, mk_out('0, '0, '0, '0, '0, '0, '0, '0, 1'b0));
        add_row(mk_in(KIND_LOAD, '0, '0, '0, -32'sd1, '0, '0, '0, '0), 1'b1,
                mk_out('0, '0, '0, -32'sd1, '0, '0, '0, '0, 1'b0));
        add_row(mk_in(KIND_COMPOSE, '0, '0, '0, 32'sd1, '0, '0, '0, 32'sd1), 1'b0, '0);
        add_row(mk_in(KIND_LOAD, '0, '0, '0, 32'sd1, 32'sd1, '0, '0, '0), 1'b1,
                mk_out('0, '0, '0, 32'sd1, 32'sd1, '0, '0, '0, 1'b0));
        add_row(mk_in(KIND_COMPOSE, 32'sd1, '0, '0, 32'sd1, '0, '0, '0, 32'sd1), 1'b0, '0);
        add_row(mk_in(KIND_LOAD, 32'sh0000_B505, '0, '0, 32'sh0000_B505, '0,
                      32'sh0002_0000, '0, '0), 1'b0, '0);
        add_row(vec_b, 1'b0, '0);
        add_row(vec_a, 1'b0, '0);
        add_row(mk_in(KIND_COMPOSE, -32'sh0000_B505, 32'sh0000_8000, -32'sh0000_4000,
                      32'sh0000_C000, -32'sh0001_0000, 32'sh0000_0003, Q_MIN, Q_MAX),
                1'b0, '0);
        add_row(mk_in(KIND_LOAD, ONE_Q16, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
        add_row(mk_in(KIND_COMPOSE, '0, Q_MAX, '0, '0, '0, '0, '0, '0), 1'b0, '0);
        add_row(mk_in(KIND_COMPOSE, '0, '0, Q_MIN, ONE_Q16, '0, ONE_Q16, '0, '0), 1'b0, '0);
        add_row(mk_in(KIND_LOAD, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h0F0F_F0F0, 32'hF0F0_0F0F,
                      32'h1234_5678, 32'h8765_4321, 32'hFFFF_0000, 32'h0000_FFFF),
                1'b0, '0);
        add_row(mk_in(KIND_COMPOSE, 32'h0000_FFFF, 32'hFFFF_0001, 32'h0001_0001,
                      32'h7FFF_FFFF, 32'h8000_0001, 32'h0000_8000, 32'hFFFF_8000,
                      32'h4000_0000), 1'b0, '0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k])
            drive_beat(plan[k].item, plan[k].typed, plan[k].want);

        for (int p = 0; p < 4; p++) begin
            drain_results();
            phase = p;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                drive_beat(rand_item(), 1'b0, '0);
        end
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("covered %0d loads and %0d composes over four idle/stall mixes",
                 loads_sent, composes_sent);
        $display("%0d results checked, %0d of them saturated", results_seen, sat_seen);
        if (mismatches == 0) begin
            $display("dual_quaternion_pose_composer_top: match");
        end else begin
            $display("%0d mismatched fields", mismatches);
            $display("dual_quaternion_pose_composer_top: mismatch");
        end
        $finish;
    end

endmodule
